[rtl/core/clsr_pkg.sv]
// ----------------------------------------------------------------------------
// clsr_pkg
// Shared constants, types and helpers of the combined congruential generator
// with shuffle table.
// ----------------------------------------------------------------------------
package clsr_pkg;

    // table size and derived index widths
    localparam int TABLE_DEPTH = 32;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 8);
    localparam int DW          = 31;
    localparam int MW          = 16;
    localparam int PW          = DW + MW;
    localparam int FW          = 8;

    // generator moduli and multipliers
    localparam logic [DW-1:0] MOD_ONE  = 31'd2147483563;
    localparam logic [DW-1:0] MOD_TWO  = 31'd2147483399;
    localparam logic [MW-1:0] MUL_ONE  = 16'd40014;
    localparam logic [MW-1:0] MUL_TWO  = 16'd40692;
    localparam logic [DW-1:0] G2_RESET = 31'd123456789;

    // 2^31 mod m, used to fold the high product bits back in
    localparam logic [FW-1:0] FOLD_ONE = FW'(64'h8000_0000 - 64'(MOD_ONE));
    localparam logic [FW-1:0] FOLD_TWO = FW'(64'h8000_0000 - 64'(MOD_TWO));

    // output wrap and slot divisor
    localparam logic [DW-1:0] WRAP_ADD = MOD_ONE - 31'd1;
    localparam logic [31:0]   SLOT_DIV = 32'(1 + (64'(MOD_ONE) - 1) / TABLE_DEPTH);

    // generator select of the shared unit
    typedef enum logic {
        GEN_ONE = 1'b0,
        GEN_TWO = 1'b1
    } t_gen_sel;

    // request into the multiply-mod unit
    typedef struct packed {
        t_gen_sel        sel;
        logic [DW-1:0]   operand;
    } t_mm_req;

    // slot = value / SLOT_DIV, as a count of thresholds passed
    function automatic logic [SLOT_W-1:0] slot_of(input logic [DW-1:0] v);
        logic [SLOT_W-1:0] n;
        logic [31:0]       thr;
        n = '0;
        for (int k = 1; k < TABLE_DEPTH; k++) begin
            thr = 32'(k) * SLOT_DIV;
            if ({1'b0, v} >= thr) begin
                n = n + SLOT_W'(1);
            end
        end
        return n;
    endfunction

endpackage

[rtl/core/clsr_mulmod.sv]
// ----------------------------------------------------------------------------
// clsr_mulmod
// Shared multiply-mod unit: (operand * a) mod m for either generator, one
// registered product stage followed by a fold and one correcting subtract.
// ----------------------------------------------------------------------------
module clsr_mulmod (
    input  logic                        i_clk,
    input  clsr_pkg::t_mm_req           i_req,
    output logic [clsr_pkg::DW-1:0]     o_res
);

    logic [clsr_pkg::PW-1:0] r_prod;
    clsr_pkg::t_gen_sel      r_sel;
    logic [clsr_pkg::MW-1:0] mul;
    logic [clsr_pkg::MW-1:0] hi;
    logic [clsr_pkg::FW-1:0] fold;
    logic [clsr_pkg::DW-1:0] modv;
    logic [23:0]             hc;
    logic [31:0]             sum;

    // multiplier constant per generator
    always_comb begin
        mul = (i_req.sel == clsr_pkg::GEN_TWO) ? clsr_pkg::MUL_TWO : clsr_pkg::MUL_ONE;
    end

    // product register
    always_ff @(posedge i_clk) begin
        r_prod <= clsr_pkg::PW'(i_req.operand) * clsr_pkg::PW'(mul);
        r_sel  <= i_req.sel;
    end

    // fold high part: 2^31 is congruent to the fold constant
    always_comb begin
        fold  = (r_sel == clsr_pkg::GEN_TWO) ? clsr_pkg::FOLD_TWO : clsr_pkg::FOLD_ONE;
        modv  = (r_sel == clsr_pkg::GEN_TWO) ? clsr_pkg::MOD_TWO : clsr_pkg::MOD_ONE;
        hi    = r_prod[clsr_pkg::PW-1:clsr_pkg::DW];
        hc    = 24'(hi) * 24'(fold);
        sum   = 32'(r_prod[clsr_pkg::DW-1:0]) + 32'(hc);
        o_res = (sum >= 32'(modv)) ? clsr_pkg::DW'(sum - 32'(modv))
                                   : sum[clsr_pkg::DW-1:0];
    end

endmodule

[rtl/core/combined_lcg_shuffle_rng.sv]
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng
// Long-period uniform generator: two combined congruential generators mixed
// through a shuffle table, with a sequencer around one multiply-mod unit.
// ----------------------------------------------------------------------------
// A draw request (tuser low) gives one value in 1..2147483562 on the master
// side after states DA, DB, DC and DOUT; the next request is taken once the
// sequencer is back in IDLE, so one draw is in flight at a time. Each draw
// advances both generators through the single shared multiply-mod unit (one
// product register, so the two steps overlap) and does one read and one write
// of the shuffle table memory. A reseed request (tuser high) first runs 40
// warm-up steps of generator one, each through states WA and WB, then a draw.
// A finished value waits in the output register; a new request is accepted
// meanwhile and its result is held back until that register is free.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [30:0] seed, [31] zero fill
    input  logic        i_s_axis_tuser,   // [0] op: 0 draw, 1 reseed then draw
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // [30:0] value, [31] zero fill
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_WA   = 7'b0000010,
        ST_WB   = 7'b0000100,
        ST_DA   = 7'b0001000,
        ST_DB   = 7'b0010000,
        ST_DC   = 7'b0100000,
        ST_DOUT = 7'b1000000
    } t_state;

    t_state                          r_state;
    logic [clsr_pkg::DW-1:0]         r_g1;
    logic [clsr_pkg::DW-1:0]         r_g2;
    logic [clsr_pkg::DW-1:0]         r_last;
    logic [clsr_pkg::CNT_W-1:0]      r_cnt;
    logic [clsr_pkg::SLOT_W-1:0]     r_slot;
    logic                            r_out_vld;
    logic [clsr_pkg::DW-1:0]         r_out;
    logic [clsr_pkg::TABLE_DEPTH-1:0] r_vld;
    logic [clsr_pkg::DW-1:0]         r_rd_data;
    logic                            r_rd_vld;
    logic [clsr_pkg::DW-1:0]         mem [clsr_pkg::TABLE_DEPTH];

    clsr_pkg::t_mm_req               mm_req;
    logic [clsr_pkg::DW-1:0]         mm_res;
    logic                            in_acc;
    logic                            out_free;
    logic [clsr_pkg::DW-1:0]         seed_red;
    logic [clsr_pkg::DW-1:0]         seed_use;
    logic [clsr_pkg::DW-1:0]         tbl_val;
    logic [31:0]                     diff;
    logic [clsr_pkg::DW-1:0]         y_val;
    logic                            we;
    logic [clsr_pkg::SLOT_W-1:0]     wa;
    logic [clsr_pkg::DW-1:0]         wd;

    // handshake
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_vld || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {1'b0, r_out};

    // seed reduced modulo the first modulus, zero taken as one
    always_comb begin
        seed_red = (i_s_axis_tdata[clsr_pkg::DW-1:0] >= clsr_pkg::MOD_ONE)
                 ? i_s_axis_tdata[clsr_pkg::DW-1:0] - clsr_pkg::MOD_ONE
                 : i_s_axis_tdata[clsr_pkg::DW-1:0];
        seed_use = (seed_red == '0) ? clsr_pkg::DW'(1) : seed_red;
    end

    // shared unit request
    always_comb begin
        mm_req.sel     = clsr_pkg::GEN_ONE;
        mm_req.operand = r_g1;
        if (r_state == ST_DB) begin
            mm_req.sel     = clsr_pkg::GEN_TWO;
            mm_req.operand = r_g2;
        end
    end

    clsr_mulmod u_mulmod (
        .i_clk (i_clk),
        .i_req (mm_req),
        .o_res (mm_res)
    );

    // draw result: table entry minus generator two, wrapped into range
    always_comb begin
        tbl_val = r_rd_vld ? r_rd_data : '0;
        diff    = 32'(tbl_val) - 32'(r_g2);
        y_val   = (diff[31] || diff == '0) ? clsr_pkg::DW'(diff + 32'(clsr_pkg::WRAP_ADD))
                                            : diff[clsr_pkg::DW-1:0];
    end

    // table write port: warm-up fill or draw refill
    always_comb begin
        we = 1'b0;
        wa = r_slot;
        wd = r_g1;
        if (r_state == ST_WB && r_cnt < clsr_pkg::CNT_W'(clsr_pkg::TABLE_DEPTH)) begin
            we = 1'b1;
            wa = r_cnt[clsr_pkg::SLOT_W-1:0];
            wd = mm_res;
        end else if (r_state == ST_DOUT && out_free) begin
            we = 1'b1;
        end
    end

    // shuffle table memory
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (r_state == ST_DB) begin
            r_rd_data <= mem[r_slot];
        end
    end

    // entry valid bits and registered read valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (we) begin
                r_vld[wa] <= 1'b1;
            end
            if (r_state == ST_DB) begin
                r_rd_vld <= r_vld[r_slot];
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_g1      <= clsr_pkg::DW'(1);
            r_g2      <= clsr_pkg::G2_RESET;
            r_last    <= '0;
            r_cnt     <= '0;
            r_slot    <= '0;
            r_out_vld <= 1'b0;
            r_out     <= '0;
        end else begin
            // output taken, unless a new value is loaded this cycle
            if (r_out_vld && i_m_axis_tready && r_state != ST_DOUT) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (i_s_axis_tuser) begin
                            r_g1    <= seed_use;
                            r_g2    <= seed_use;
                            r_cnt   <= clsr_pkg::CNT_W'(clsr_pkg::TABLE_DEPTH + 7);
                            r_state <= ST_WA;
                        end else begin
                            r_state <= ST_DA;
                        end
                    end
                end
                // warm-up: product of generator one
                ST_WA: begin
                    r_state <= ST_WB;
                end
                // warm-up: step lands, last steps fill the table
                ST_WB: begin
                    r_g1 <= mm_res;
                    if (r_cnt == '0) begin
                        r_last  <= mm_res;
                        r_state <= ST_DA;
                    end else begin
                        r_cnt   <= r_cnt - clsr_pkg::CNT_W'(1);
                        r_state <= ST_WA;
                    end
                end
                // draw: generator one product, slot from last output (or last warm-up step)
                ST_DA: begin
                    r_slot  <= clsr_pkg::slot_of(r_last);
                    r_state <= ST_DB;
                end
                // draw: generator one lands, generator two product, table read
                ST_DB: begin
                    r_g1    <= mm_res;
                    r_state <= ST_DC;
                end
                // draw: generator two lands
                ST_DC: begin
                    r_g2    <= mm_res;
                    r_state <= ST_DOUT;
                end
                // draw: result out once the output register is free
                ST_DOUT: begin
                    if (out_free) begin
                        r_out     <= y_val;
                        r_out_vld <= 1'b1;
                        r_last    <= y_val;
                        r_state   <= ST_IDLE;
                    end else if (r_out_vld && i_m_axis_tready) begin
                        r_out_vld <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // every delivered value lies in 1..2147483562
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_out != '0 && r_out <= clsr_pkg::WRAP_ADD))
        else $error("output value out of range");

    // generator one never leaves 1..m-1
    a_g1_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_g1 != '0 && r_g1 < clsr_pkg::MOD_ONE))
        else $error("generator one out of range");

    // a plain draw request has a value waiting on the master side after its draw states
    a_draw_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_s_axis_tuser) |-> ##5 o_m_axis_tvalid)
        else $error("draw result missing");

endmodule

[test/combined_lcg_shuffle_rng_tb.sv]
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng_tb
// Self-checking bench for the combined congruential generator with shuffle
// table: a short table of directed requests, then random draws and reseeds
// under several idling mixes and one long output hold-off, each value checked
// against a typed value or a cycle-free predictor of generators and shuffle table.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng_tb;

    localparam int DEPTH = clsr_pkg::TABLE_DEPTH;

    // generator constants, Schrage split of each modulus
    localparam longint M1      = 64'd2147483563;
    localparam longint M2      = 64'd2147483399;
    localparam longint A1      = 64'd40014;
    localparam longint A2      = 64'd40692;
    localparam longint Q1      = 64'd53668;
    localparam longint Q2      = 64'd52774;
    localparam longint R1      = 64'd12211;
    localparam longint R2      = 64'd3791;
    localparam longint WRAP    = M1 - 64'd1;
    localparam longint SLOT_SZ = 64'd1 + (M1 - 64'd1) / DEPTH;

    localparam int N_RANDOM   = 800;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN_MAX  = 200000;
    localparam int SETTLE_CYC = 120;

    typedef enum logic {
        OP_DRAW   = 1'b0,
        OP_RESEED = 1'b1
    } t_rng_op;

    typedef struct {
        t_rng_op     op;
        logic [30:0] seed;
        bit          known;
        logic [30:0] value;
    } t_stim_row;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [31:0] s_data  = '0;
    logic        s_user  = 1'b0;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [31:0] m_data;

    // predictor state
    logic [30:0] gen_one;
    logic [30:0] gen_two;
    logic [30:0] prev_value;
    logic [30:0] mix_table [DEPTH];

    logic [30:0] value_queue [$];
    logic [30:0] want;
    int          fail_cnt   = 0;
    int          src_idle   = 0;
    int          sink_stall = 0;
    bit          hold_armed = 1'b0;
    bit          hold_done  = 1'b0;
    int          hold_left  = 0;

    t_stim_row   dir_rows [18];

    combined_lcg_shuffle_rng dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),    // [30:0] seed, [31] zero fill
        .i_s_axis_tuser  (s_user),    // [0] op
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)     // [30:0] value, [31] zero fill
    );

    always #1 i_clk = ~i_clk;

    // run ends here if the block hangs
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    // one multiply-mod step by Schrage's method
    function automatic logic [30:0] mulmod(input logic [30:0] s, input longint mul,
                                           input longint quo, input longint rem,
                                           input longint m);
        longint k;
        longint r;
        k = longint'(s) / quo;
        r = mul * (longint'(s) - k * quo) - k * rem;
        if (r < 0) r += m;
        if (r < 0) r += m;
        if (r >= m) r -= m;
        return r[30:0];
    endfunction

    task automatic clear_state();
        gen_one    = 31'd1;
        gen_two    = 31'd123456789;
        prev_value = '0;
        for (int i = 0; i < DEPTH; i++) mix_table[i] = '0;
    endtask

    // advance the predictor by one request, return the value it yields
    function automatic logic [30:0] next_value(input t_rng_op op, input logic [30:0] seed);
        longint s;
        longint slot;
        longint y;
        if (op == OP_RESEED) begin
            s = longint'(seed) % M1;
            if (s == 0) s = 1;
            gen_one = s[30:0];
            gen_two = s[30:0];
            // warm-up, last steps fill the table from the top slot down
            for (int j = DEPTH + 7; j >= 0; j--) begin
                gen_one = mulmod(gen_one, A1, Q1, R1, M1);
                if (j < DEPTH) mix_table[j] = gen_one;
            end
            prev_value = mix_table[0];
        end
        gen_one = mulmod(gen_one, A1, Q1, R1, M1);
        gen_two = mulmod(gen_two, A2, Q2, R2, M2);
        slot = longint'(prev_value) / SLOT_SZ;
        if (slot >= DEPTH) slot = DEPTH - 1;
        y = longint'(mix_table[slot]) - longint'(gen_two);
        mix_table[slot] = gen_one;
        if (y < 1) y += WRAP;
        prev_value = y[30:0];
        return y[30:0];
    endfunction

    // offer one request, wait for its acceptance, queue the expected value
    task automatic push_request(input t_rng_op op, input logic [30:0] seed,
                                input bit known, input logic [30:0] typed);
        logic [30:0] predicted;
        while ($urandom_range(0, 99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= {1'b0, seed};
        do @(posedge i_clk); while (s_ready !== 1'b1);
        predicted = next_value(op, seed);
        value_queue.push_back(known ? typed : predicted);
    endtask

    // random seed, weighted towards the modulus edges and tiny values
    function automatic logic [30:0] pick_seed();
        case ($urandom_range(0, 9))
            0:       return 31'($urandom_range(0, 3));
            1:       return 31'($urandom_range(2147483560, 2147483647));
            2:       return 31'($urandom_range(2147483390, 2147483410));
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic run_random(input int n_items, input int idle_pct, input int stall_pct);
        t_rng_op op;
        src_idle   = idle_pct;
        sink_stall = stall_pct;
        for (int i = 0; i < n_items; i++) begin
            op = ($urandom_range(0, 99) < 8) ? OP_RESEED : OP_DRAW;
            push_request(op, pick_seed(), 1'b0, '0);
        end
    endtask

    // output side: random stall, plus one long hold-off when armed
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_armed && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= sink_stall);
        end
    end

    // compare each delivered value with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            if (value_queue.size() == 0) begin
                if (fail_cnt < 10) $display("unexpected result %0d", m_data);
                fail_cnt++;
            end else begin
                want = value_queue.pop_front();
                if (m_data !== {1'b0, want}) begin
                    if (fail_cnt < 10)
                        $display("value mismatch: expected %0d, got %0d", want, m_data);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        int waited;
        // directed requests; only the first draw after reset is typed in
        dir_rows = '{
            '{OP_DRAW,   31'd0,          1'b1, 31'd1407495835},
            '{OP_DRAW,   31'h7FFFFFFF,   1'b0, 31'd0},
            '{OP_DRAW,   31'd0,          1'b0, 31'd0},
            '{OP_RESEED, 31'd0,          1'b0, 31'd0},  // zero seed taken as one
            '{OP_DRAW,   31'd0,          1'b0, 31'd0},
            '{OP_RESEED, 31'd1,          1'b0, 31'd0},
            '{OP_DRAW,   31'h55555555,   1'b0, 31'd0},
            '{OP_RESEED, 31'h7FFFFFFF,   1'b0, 31'd0},  // above first modulus
            '{OP_DRAW,   31'd0,          1'b0, 31'd0},
            '{OP_RESEED, 31'd2147483563, 1'b0, 31'd0},  // reduces to zero
            '{OP_RESEED, 31'd2147483562, 1'b0, 31'd0},  // largest seed in range
            '{OP_DRAW,   31'd0,          1'b0, 31'd0},
            '{OP_RESEED, 31'd2147483399, 1'b0, 31'd0},  // second generator at modulus
            '{OP_DRAW,   31'd0,          1'b0, 31'd0},
            '{OP_RESEED, 31'd2147483500, 1'b0, 31'd0},  // second generator above modulus
            '{OP_DRAW,   31'd0,          1'b0, 31'd0},
            '{OP_RESEED, 31'h2AAAAAAA,   1'b0, 31'd0},
            '{OP_RESEED, 31'h55555555,   1'b0, 31'd0}
        };
        clear_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            push_request(dir_rows[i].op, dir_rows[i].seed, dir_rows[i].known,
                         dir_rows[i].value);

        run_random(N_RANDOM / 4, 0, 0);
        run_random(N_RANDOM / 4, 84, 0);
        run_random(N_RANDOM / 4, 0, 84);
        run_random(N_RANDOM / 4, 14, 14);

        // long output hold-off while requests keep coming
        hold_armed <= 1'b1;
        src_idle   = 0;
        sink_stall = 0;
        for (int i = 0; i < 40; i++) push_request(OP_DRAW, 31'($urandom), 1'b0, '0);
        run_random(20, 0, 0);

        s_valid <= 1'b0;
        waited = 0;
        while (value_queue.size() != 0 && waited < DRAIN_MAX) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (value_queue.size() != 0) begin
            if (fail_cnt < 10) $display("%0d results never arrived", value_queue.size());
            fail_cnt++;
        end

        if (fail_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
